// ----- sv/bso_pkg.sv -----
// Shared types and constants for the box and sphere overlap test unit.
// No dependencies; every other file imports this package.
package bso_pkg;

	localparam int ACTION_W = 2;
	localparam int FIELD_W = 32;
	localparam int RAD_W = 31;
	localparam int RSUM_W = RAD_W + 1;
	localparam int RR_W = 2 * RSUM_W;
	localparam int STAGES = 6;

	localparam logic [ACTION_W-1:0] ACT_BOX_POINT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_BOX_SPHERE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_SPHERE_SPHERE = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_SPHERE_POINT = 2'd3;

	// Per-word control that rides down the pipeline beside the arithmetic.
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic inside_box;
	} tag_t;

endpackage

// ----- sv/bso_if.sv -----
// Handshake interfaces for the query and result channels.
// Depends on bso_pkg for the field widths.
interface bso_req_if import bso_pkg::*; ();
	logic valid;
	logic ready;
	logic [ACTION_W-1:0] action;
	logic signed [FIELD_W-1:0] first_x;
	logic signed [FIELD_W-1:0] first_y;
	logic signed [FIELD_W-1:0] first_z;
	logic signed [FIELD_W-1:0] box_max_x;
	logic signed [FIELD_W-1:0] box_max_y;
	logic signed [FIELD_W-1:0] box_max_z;
	logic signed [FIELD_W-1:0] probe_x;
	logic signed [FIELD_W-1:0] probe_y;
	logic signed [FIELD_W-1:0] probe_z;
	logic [RAD_W-1:0] radius_first;
	logic [RAD_W-1:0] radius_second;

	modport source (
		output valid, action, first_x, first_y, first_z, box_max_x, box_max_y, box_max_z,
		output probe_x, probe_y, probe_z, radius_first, radius_second,
		input ready
	);
	modport sink (
		input valid, action, first_x, first_y, first_z, box_max_x, box_max_y, box_max_z,
		input probe_x, probe_y, probe_z, radius_first, radius_second,
		output ready
	);
endinterface

interface bso_rsp_if import bso_pkg::*; ();
	logic valid;
	logic ready;
	logic hit;

	modport source (output valid, hit, input ready);
	modport sink (input valid, hit, output ready);
endinterface

// ----- sv/bso_axis.sv -----
// One coordinate axis, pipeline stages 1 to 4: clamp, absolute gap, partial
// products and the assembled square. Depends on bso_pkg.
module bso_axis import bso_pkg::*; #(
	parameter int CW = 32
) (
	input logic clk,
	input logic [3:0] en,
	input logic box_sphere,
	input logic [FIELD_W-1:0] first_raw,
	input logic [FIELD_W-1:0] bmax_raw,
	input logic [FIELD_W-1:0] probe_raw,
	output logic inside_s1,
	output logic [2*CW-1:0] sq_s4
);

	localparam int LO_W = (CW + 1) / 2;
	localparam int HI_W = CW - LO_W;

	logic [CW+FIELD_W-1:0] first_ext, bmax_ext, probe_ext;
	logic [CW-1:0] first_c, bmax_c, probe_c;
	logic [CW-1:0] first_b, bmax_b, probe_b;
	logic [CW-1:0] upper, nearest;
	logic [CW-1:0] a_s1, b_s1;
	logic [CW-1:0] gap_s2;
	logic [2*HI_W-1:0] hh_s3;
	logic [HI_W+LO_W-1:0] hl_s3;
	logic [2*LO_W-1:0] ll_s3;

	// Fields wider than the coordinate are truncated; narrower ones are zero-extended.
	assign first_ext = {{CW{1'b0}}, first_raw};
	assign bmax_ext = {{CW{1'b0}}, bmax_raw};
	assign probe_ext = {{CW{1'b0}}, probe_raw};
	assign first_c = first_ext[CW-1:0];
	assign bmax_c = bmax_ext[CW-1:0];
	assign probe_c = probe_ext[CW-1:0];

	// Offset binary so that unsigned compares give the signed order.
	assign first_b = {~first_c[CW-1], first_c[CW-2:0]};
	assign bmax_b = {~bmax_c[CW-1], bmax_c[CW-2:0]};
	assign probe_b = {~probe_c[CW-1], probe_c[CW-2:0]};

	assign upper = (probe_b < bmax_b) ? probe_b : bmax_b;
	assign nearest = (first_b > upper) ? first_b : upper;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			inside_s1 <= (probe_b > first_b) && (probe_b < bmax_b);
			a_s1 <= probe_b;
			b_s1 <= box_sphere ? nearest : first_b;
		end
		if (en[1]) begin
			gap_s2 <= (a_s1 >= b_s1) ? (a_s1 - b_s1) : (b_s1 - a_s1);
		end
		if (en[2]) begin
			hh_s3 <= gap_s2[CW-1:LO_W] * gap_s2[CW-1:LO_W];
			hl_s3 <= gap_s2[CW-1:LO_W] * gap_s2[LO_W-1:0];
			ll_s3 <= gap_s2[LO_W-1:0] * gap_s2[LO_W-1:0];
		end
		if (en[3]) begin
			// The high and low squares do not overlap, so they concatenate.
			sq_s4 <= {hh_s3, ll_s3} + ((2*CW)'(hl_s3) << (LO_W + 1));
		end
	end

endmodule

// ----- sv/bso_reduce.sv -----
// Pipeline stages 5 and 6: sum of the three squares and the final compare.
// Depends on bso_pkg.
module bso_reduce import bso_pkg::*; #(
	parameter int CW = 32
) (
	input logic clk,
	input logic [1:0] en,
	input logic [2*CW-1:0] sq_x,
	input logic [2*CW-1:0] sq_y,
	input logic [2*CW-1:0] sq_z,
	input logic [RR_W-1:0] rr_s4,
	input tag_t tag_s4,
	output logic hit_s6
);

	localparam int SUM_W = 2 * CW + 2;
	localparam int CMP_W = (SUM_W > RR_W) ? SUM_W : RR_W;

	logic [SUM_W-1:0] sum_s5;
	logic [RR_W-1:0] rr_s5;
	tag_t tag_s5;
	logic [CMP_W-1:0] sum_cmp, rr_cmp;

	assign sum_cmp = CMP_W'(sum_s5);
	assign rr_cmp = CMP_W'(rr_s5);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sum_s5 <= SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
			rr_s5 <= rr_s4;
			tag_s5 <= tag_s4;
		end
		if (en[1]) begin
			hit_s6 <= (tag_s5.action == ACT_BOX_POINT) ? tag_s5.inside_box
				: (sum_cmp <= rr_cmp);
		end
	end

endmodule

// ----- sv/box_sphere_overlap_tests_top.sv -----
// Box and sphere overlap test unit, top level.
// Depends on bso_pkg, bso_if, bso_axis and bso_reduce.
//
// Each query word on req selects one of four tests by its action field:
// point strictly inside a box, box against sphere, sphere against sphere,
// and point within or on a sphere. The result word on rsp carries one hit
// bit. Distances are compared as exact squares, so touching spheres hit.
//
// The pipeline has six register stages; the last is the output register.
// Each word moves through the stage registers in turn to rsp. With rsp.ready
// high, a new word can be accepted every cycle: throughput is one word per cycle.
// Every stage has its own valid bit and takes a word whenever it is empty or
// its successor moves, so bubbles close up behind a stalled receiver.
// When rsp.ready is low the held result stays on rsp and the stages behind
// it keep filling; req.ready drops only once all six stages are full.
// Reset clears every valid bit; no result is offered until new words arrive.
// The full-width squares, 64 bits at the default width, are built from
// three half-width products per axis.
module box_sphere_overlap_tests_top import bso_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	bso_req_if.sink req,
	bso_rsp_if.source rsp
);

	logic [STAGES:1] valid_q;
	logic [STAGES+1:1] ready_v;
	logic [STAGES:1] en;
	logic [STAGES:0] valid_in;

	logic [ACTION_W-1:0] act_s1;
	logic [RSUM_W-1:0] rsum_s1, rsum_s2;
	logic [RR_W-1:0] rr_s3, rr_s4;
	tag_t tag_s2, tag_s3, tag_s4;
	logic in_x, in_y, in_z;
	logic [2*COORD_WIDTH-1:0] sq_x, sq_y, sq_z;
	logic box_sphere;
	logic hit_s6;

	assign valid_in = {valid_q, req.valid};

	// Ready ripples back from the output, so the last stage is resolved first.
	always_comb begin
		ready_v[STAGES+1] = rsp.ready;
		for (int k = STAGES; k >= 1; k--) begin
			ready_v[k] = !valid_q[k] || ready_v[k+1];
			en[k] = ready_v[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 1; k <= STAGES; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_in[k-1];
				end
			end
		end
	end

	assign req.ready = ready_v[1];
	assign rsp.valid = valid_q[STAGES];
	assign rsp.hit = hit_s6;

	assign box_sphere = (req.action == ACT_BOX_SPHERE);

	// Radius path: the sphere-sphere test compares against the radius sum.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			act_s1 <= req.action;
			rsum_s1 <= (req.action == ACT_SPHERE_SPHERE)
				? (RSUM_W'(req.radius_first) + RSUM_W'(req.radius_second))
				: RSUM_W'(req.radius_first);
		end
		if (en[2]) begin
			rsum_s2 <= rsum_s1;
			tag_s2.action <= act_s1;
			tag_s2.inside_box <= in_x && in_y && in_z;
		end
		if (en[3]) begin
			rr_s3 <= rsum_s2 * rsum_s2;
			tag_s3 <= tag_s2;
		end
		if (en[4]) begin
			rr_s4 <= rr_s3;
			tag_s4 <= tag_s3;
		end
	end

	bso_axis #(.CW(COORD_WIDTH)) u_axis_x (
		.clk(clk), .en(en[4:1]), .box_sphere(box_sphere),
		.first_raw(req.first_x), .bmax_raw(req.box_max_x), .probe_raw(req.probe_x),
		.inside_s1(in_x), .sq_s4(sq_x)
	);

	bso_axis #(.CW(COORD_WIDTH)) u_axis_y (
		.clk(clk), .en(en[4:1]), .box_sphere(box_sphere),
		.first_raw(req.first_y), .bmax_raw(req.box_max_y), .probe_raw(req.probe_y),
		.inside_s1(in_y), .sq_s4(sq_y)
	);

	bso_axis #(.CW(COORD_WIDTH)) u_axis_z (
		.clk(clk), .en(en[4:1]), .box_sphere(box_sphere),
		.first_raw(req.first_z), .bmax_raw(req.box_max_z), .probe_raw(req.probe_z),
		.inside_s1(in_z), .sq_s4(sq_z)
	);

	bso_reduce #(.CW(COORD_WIDTH)) u_reduce (
		.clk(clk), .en(en[6:5]),
		.sq_x(sq_x), .sq_y(sq_y), .sq_z(sq_z),
		.rr_s4(rr_s4), .tag_s4(tag_s4),
		.hit_s6(hit_s6)
	);

endmodule
